FILE: sv/pndc_pkg.sv
// Shared types and constants of the Petri net deadlock checker.
package pndc_pkg;

    typedef enum logic [2:0] {
        MODE_WR_ARC   = 3'd0,
        MODE_WR_TRANS = 3'd1,
        MODE_WR_PLACE = 3'd2,
        MODE_WR_MARK  = 3'd3,
        MODE_DEADLOCK = 3'd4,
        MODE_FIREABLE = 3'd5,
        MODE_RSVD6    = 3'd6,
        MODE_RSVD7    = 3'd7
    } mode_t;

    localparam logic CFG_PLACE_COUNT = 1'b0;
    localparam logic CFG_TRANS_COUNT = 1'b1;

    localparam logic KIND_DEADLOCK = 1'b0;
    localparam logic KIND_FIREABLE = 1'b1;

    typedef struct packed {
        logic [12:0] second_pointer;
        logic [12:0] first_pointer;
        logic        arc_is_inhibitor;
        logic [31:0] token_value;
        logic [7:0]  arc_place;
        logic [11:0] slot;
    } in_data_t;

    typedef struct packed {
        logic        inhibitor;
        logic [31:0] weight;
        logic [7:0]  place;
    } arc_t;

    typedef struct packed {
        logic [12:0] post;
        logic [12:0] pre;
    } trans_t;

endpackage

FILE: sv/petri_net_deadlock_checker_core.sv
// Top level of the Petri net deadlock checker: table stores and query sequencer.
//
// Input channel s_*: one transfer is one item. Modes 0..3 write the arc,
// transition range, place pointer and marking stores.
// Mode 4 asks whether the net is deadlocked, mode 5 whether transition
// slot is fireable; each gives one result on m_* (answer in tdata bit 0,
// kind in tuser). Modes 6 and 7 are dropped.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready; index 0 is
// place_count, index 1 transition_count. Write only while idle.
// A fireable query reads the transition range, then each preset arc and
// its place marking, and ends at the first arc that fails; a non-transition
// slot goes straight to the result. A deadlock query reads each place's
// marking and, for each visited place, walks its transitions and their arcs;
// every step waits on one registered read of a store.
// The block takes no new item while a query runs. A result waits in the
// output register until m_tready; a further query stalls at its end until
// that register is free, and no writes are accepted during that stall.
// Reset clears control state and both registers; the stores are undefined
// until written.
module petri_net_deadlock_checker_core #(
    parameter int MAX_PLACES      = 256,
    parameter int MAX_TRANSITIONS = 1024,
    parameter int MAX_ARCS        = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[11:0], arc_place[19:12], token_value[51:20], arc_is_inhibitor[52],
    // first_pointer[65:53], second_pointer[78:66], zero[79]
    input  logic [79:0] s_tdata,
    // mode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // answer[0], zero[7:1]
    output logic [7:0]  m_tdata,
    // answer_kind[0]
    output logic        m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AAW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
    localparam int TAW = $clog2(MAX_TRANSITIONS + 1);
    localparam int PCW = $clog2(MAX_PLACES + 1);
    localparam int MAW = (MAX_PLACES > 1) ? $clog2(MAX_PLACES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_P_CHK, ST_P_M, ST_P_END, ST_T_LOOP, ST_TR_WAIT, ST_TR_DATA,
        ST_A_CHK, ST_A_DATA, ST_A_MK, ST_DONE
    } state_t;

    pndc_pkg::arc_t   arc_mem   [MAX_ARCS];
    pndc_pkg::trans_t trans_mem [MAX_TRANSITIONS + 1];
    logic [10:0]      pptr_mem  [MAX_PLACES + 1];
    logic [31:0]      mark_mem  [MAX_PLACES];

    pndc_pkg::arc_t   arc_q;
    pndc_pkg::trans_t trans_q;
    logic [10:0]      pptr_q;
    logic [31:0]      mark_q;

    state_t           state_reg;
    logic [8:0]       pcount_reg;
    logic [10:0]      tcount_reg;
    logic [PCW-1:0]   p_reg;
    logic [11:0]      t_reg;
    logic [10:0]      tend_reg;
    logic [12:0]      a_reg;
    logic [12:0]      aend_reg;
    logic             kind_reg;
    logic             ans_reg;
    logic             place_ok_reg;
    logic             m_valid_reg;
    logic             m_answer_reg;
    logic             m_kind_reg;

    pndc_pkg::in_data_t in_d;
    pndc_pkg::mode_t    in_mode;
    logic               s_xfer;
    logic [PCW-1:0]     pptr_addr;
    logic [MAW-1:0]     mark_addr;
    logic [12:0]        post_clamp;
    logic [10:0]        tend_clamp;
    logic [31:0]        tokens;
    logic               holds;
    logic               arc_fail;

    assign in_d      = pndc_pkg::in_data_t'(s_tdata[78:0]);
    assign in_mode   = pndc_pkg::mode_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'd0, m_answer_reg};
    assign m_tuser   = m_kind_reg;

    assign pptr_addr = (state_reg == ST_P_M) ? PCW'(p_reg + 1'b1) : p_reg;
    assign mark_addr = (state_reg == ST_A_DATA) ? MAW'(arc_q.place) : MAW'(p_reg);
    assign post_clamp = (32'(trans_q.post) > MAX_ARCS) ? 13'(MAX_ARCS) : trans_q.post;
    assign tend_clamp = (32'(pptr_q) > MAX_TRANSITIONS + 1) ? 11'(MAX_TRANSITIONS + 1)
                                                             : pptr_q;
    assign tokens   = place_ok_reg ? mark_q : 32'd0;
    assign holds    = (tokens >= arc_q.weight);
    assign arc_fail = arc_q.inhibitor ? holds : !holds;

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            if (in_mode == pndc_pkg::MODE_WR_ARC && 32'(in_d.slot) < MAX_ARCS) begin
                arc_mem[AAW'(in_d.slot)] <= '{inhibitor: in_d.arc_is_inhibitor,
                                              weight: in_d.token_value,
                                              place: in_d.arc_place};
            end
            if (in_mode == pndc_pkg::MODE_WR_TRANS
                    && 32'(in_d.slot) < MAX_TRANSITIONS + 1) begin
                trans_mem[TAW'(in_d.slot)] <= '{post: in_d.second_pointer,
                                                pre: in_d.first_pointer};
            end
            if (in_mode == pndc_pkg::MODE_WR_PLACE && 32'(in_d.slot) < MAX_PLACES + 1) begin
                pptr_mem[PCW'(in_d.slot)] <= in_d.first_pointer[10:0];
            end
            if (in_mode == pndc_pkg::MODE_WR_MARK && 32'(in_d.slot) < MAX_PLACES) begin
                mark_mem[MAW'(in_d.slot)] <= in_d.token_value;
            end
        end
        arc_q   <= arc_mem[AAW'(a_reg)];
        trans_q <= trans_mem[TAW'(t_reg)];
        pptr_q  <= pptr_mem[pptr_addr];
        mark_q  <= mark_mem[mark_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pcount_reg  <= '0;
            tcount_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    pndc_pkg::CFG_PLACE_COUNT: pcount_reg <= cfg_data[8:0];
                    pndc_pkg::CFG_TRANS_COUNT: tcount_reg <= cfg_data[10:0];
                endcase
            end
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        p_reg <= '0;
                        t_reg <= in_d.slot;
                        if (in_mode == pndc_pkg::MODE_DEADLOCK) begin
                            kind_reg <= pndc_pkg::KIND_DEADLOCK;
                            if (pcount_reg == 9'd0) begin
                                ans_reg   <= (tcount_reg == 11'd0);
                                state_reg <= ST_DONE;
                            end else begin
                                state_reg <= ST_P_CHK;
                            end
                        end else if (in_mode == pndc_pkg::MODE_FIREABLE) begin
                            kind_reg <= pndc_pkg::KIND_FIREABLE;
                            if (in_d.slot < 12'(tcount_reg)
                                    && 32'(in_d.slot) < MAX_TRANSITIONS + 1) begin
                                state_reg <= ST_TR_WAIT;
                            end else begin
                                ans_reg   <= 1'b0;
                                state_reg <= ST_DONE;
                            end
                        end
                    end
                end
                ST_P_CHK: begin
                    if (32'(p_reg) < 32'(pcount_reg) && 32'(p_reg) < MAX_PLACES) begin
                        state_reg <= ST_P_M;
                    end else begin
                        ans_reg   <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                end
                ST_P_M: begin
                    if (p_reg != '0 && mark_q == 32'd0) begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= ST_P_CHK;
                    end else begin
                        t_reg     <= {1'b0, pptr_q};
                        state_reg <= ST_P_END;
                    end
                end
                ST_P_END: begin
                    tend_reg  <= tend_clamp;
                    state_reg <= ST_T_LOOP;
                end
                ST_T_LOOP: begin
                    if (t_reg >= {1'b0, tend_reg}) begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= ST_P_CHK;
                    end else begin
                        state_reg <= ST_TR_DATA;
                    end
                end
                ST_TR_WAIT: begin
                    state_reg <= ST_TR_DATA;
                end
                ST_TR_DATA: begin
                    a_reg     <= trans_q.pre;
                    aend_reg  <= post_clamp;
                    state_reg <= ST_A_CHK;
                end
                ST_A_CHK: begin
                    if (a_reg >= aend_reg) begin
                        // transition enabled
                        if (kind_reg == pndc_pkg::KIND_FIREABLE) begin
                            ans_reg <= 1'b1;
                        end else begin
                            ans_reg <= 1'b0;
                        end
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_A_DATA;
                    end
                end
                ST_A_DATA: begin
                    place_ok_reg <= (32'(arc_q.place) < MAX_PLACES);
                    state_reg    <= ST_A_MK;
                end
                ST_A_MK: begin
                    if (arc_fail) begin
                        if (kind_reg == pndc_pkg::KIND_FIREABLE) begin
                            ans_reg   <= 1'b0;
                            state_reg <= ST_DONE;
                        end else begin
                            t_reg     <= t_reg + 1'b1;
                            state_reg <= ST_T_LOOP;
                        end
                    end else begin
                        a_reg     <= a_reg + 1'b1;
                        state_reg <= ST_A_CHK;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg  <= 1'b1;
                        m_answer_reg <= ans_reg;
                        m_kind_reg   <= kind_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_query_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (in_mode == pndc_pkg::MODE_DEADLOCK || in_mode == pndc_pkg::MODE_FIREABLE))
        |=> (state_reg != ST_IDLE))
        else $error("query transfer did not start a query");

    a_write_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && in_mode != pndc_pkg::MODE_DEADLOCK && in_mode != pndc_pkg::MODE_FIREABLE)
        |=> (state_reg == ST_IDLE))
        else $error("write transfer left idle");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside done state");

    a_arc_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_A_MK) |-> ($past(state_reg) == ST_A_DATA))
        else $error("arc check without marking read");

endmodule
